@@ rtl/tri_state_key_action_tracker_macros.svh @@
// Assertion macros for the tri-state key session tracker.
// No dependencies; included by the modules that carry assertions.
`ifndef TRI_STATE_KEY_ACTION_TRACKER_MACROS_SVH
`define TRI_STATE_KEY_ACTION_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define TSK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TSK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSK_ASSERT(label, clk, rst, prop, msg)
`define TSK_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/tsk_pkg.sv @@
// Shared types and constants for the tri-state key session tracker.
// No dependencies.
`timescale 1ns / 1ps
package tsk_pkg;
   localparam int SlotsDefault = 10;
   localparam int KeysDefault  = 128;

   localparam logic [2:0] FUNC_PRESS   = 3'd0;
   localparam logic [2:0] FUNC_RELEASE = 3'd1;
   localparam logic [2:0] FUNC_OTHER   = 3'd2;
   localparam logic [2:0] FUNC_LAYER   = 3'd3;
   localparam logic [2:0] FUNC_TICK    = 3'd4;

   localparam logic [1:0] BIND_START = 2'd0;
   localparam logic [1:0] BIND_CONT  = 2'd1;
   localparam logic [1:0] BIND_END   = 2'd2;

   localparam logic [2:0] CSR_TIMEOUT   = 3'd0;
   localparam logic [2:0] CSR_HOLD      = 3'd1;
   localparam logic [2:0] CSR_LAYER_IGN = 3'd2;
   localparam logic [2:0] CSR_KEYS_LO   = 3'd3;
   localparam logic [2:0] CSR_KEYS_HI   = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [6:0]  key_position;
      logic        key_down;
      logic [4:0]  layer_index;
      logic        layer_on;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  action_binding;
      logic        action_press;
      logic [6:0]  action_position;
      logic [15:0] action_hold_ms;
      logic        status;
      logic        last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [2:0]  func;
      logic [6:0]  key_position;
      logic        key_down;
      logic        key_ign;
      logic        layer_end;
      logic [31:0] now_ms;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_EMIT, ST_DONE
   } back_state_type;
endpackage

@@ rtl/tsk_front.sv @@
// Front end: accepts items, classifies them against the ignore masks, queues them.
// Depends on tsk_pkg.
`timescale 1ns / 1ps
module tsk_front #(
   parameter int KEY_POSITIONS = tsk_pkg::KeysDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsk_pkg::req_type req_data,
   input  logic [31:0]      layer_mask,
   input  logic [127:0]     key_mask,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output tsk_pkg::cmd_type cmd_data
);
   import tsk_pkg::*;
   `include "tri_state_key_action_tracker_macros.svh"

   // two-entry queue
   cmd_type   q_ff [2];
   cmd_type   q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   logic [KEY_POSITIONS-1:0] keys;

   assign keys = key_mask[KEY_POSITIONS-1:0];
   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign pop  = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = q_ff[rd_ff];

   always_comb begin
      q_in.func         = req_data.func;
      q_in.key_position = req_data.key_position;
      q_in.key_down     = req_data.key_down;
      q_in.key_ign      = keys[req_data.key_position[$clog2(KEY_POSITIONS)-1:0]];
      q_in.layer_end    = req_data.layer_on && !layer_mask[req_data.layer_index];
      q_in.now_ms       = req_data.now_ms;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end

   `TSK_ASSERT(a_no_overflow, clock, reset, push |-> cnt_ff != 2'd2, "queue overflow")
   `TSK_ASSERT(a_cnt_range, clock, reset, cnt_ff != 2'd3, "queue count out of range")
   `TSK_ASSERT(a_pop_nonempty, clock, reset, pop |-> cnt_ff != 2'd0, "pop from empty")
endmodule

@@ rtl/tsk_back.sv @@
// Back end: scans the session slots one per cycle, pausing while it emits result items.
// Depends on tsk_pkg.
`timescale 1ns / 1ps
module tsk_back #(
   parameter int SESSION_SLOTS = tsk_pkg::SlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  tsk_pkg::cmd_type cmd_data,
   input  logic [15:0]      idle_ms,
   input  logic [15:0]      hold_ms,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsk_pkg::rsp_type rsp_data
);
   import tsk_pkg::*;
   `include "tri_state_key_action_tracker_macros.svh"

   localparam int IW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(SESSION_SLOTS - 1);

   logic [SESSION_SLOTS-1:0] act_ff, prs_ff, fst_ff, arm_ff;
   logic [6:0]  pos_ff [SESSION_SLOTS];
   logic [31:0] dl_ff  [SESSION_SLOTS];

   back_state_type st_ff, st_in;
   cmd_type   c_ff;
   logic [IW-1:0] idx_ff, idx_in;
   // pending emission sequence: up to three results, held in a queue of four slots
   rsp_type   seq_ff [4];
   rsp_type   seq_in [4];
   logic [2:0] seq_n_ff, seq_n_in, seq_i_ff, seq_i_in;
   logic       stop_ff, stop_in;    // end scan after emission
   logic       found_ff, found_in;  // press: existing slot found
   logic       free_ok_ff, free_ok_in;
   logic [IW-1:0] free_ff, free_in;
   rsp_type    out_ff, out_in;
   logic       ov_ff, ov_in;

   // slot writes decided combinationally
   logic       wr;
   logic [IW-1:0] wi;
   logic       w_act, w_prs, w_fst, w_arm, w_dl;
   logic [6:0] w_pos;
   logic [31:0] w_dlv, dsub;
   logic       hit, last_slot, is_last;
   rsp_type    r0, r1, r2, r3;

   // tick look-ahead: sessions further on that will still end
   logic [31:0] tdiff [SESSION_SLOTS];
   logic [SESSION_SLOTS-1:0] due, later;
   logic       more_due;

   assign cmd_ready = (st_ff == ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign hit = act_ff[idx_ff] && pos_ff[idx_ff] == c_ff.key_position;
   assign last_slot = (idx_ff == LastIdx);
   assign dsub = c_ff.now_ms - dl_ff[idx_ff];
   assign more_due = |(due & later);
   assign is_last = (seq_i_ff + 3'd1 == seq_n_ff) && (stop_ff || last_slot || !more_due);

   always_comb begin
      for (int j = 0; j < SESSION_SLOTS; j++) begin
         tdiff[j] = c_ff.now_ms - dl_ff[j];
         due[j]   = arm_ff[j] && act_ff[j] && !prs_ff[j] && !tdiff[j][31];
         later[j] = (j > int'(idx_ff));
      end
   end

   function automatic rsp_type mk(logic [1:0] b, logic p, logic [6:0] q, logic [15:0] h);
      rsp_type r;
      r = '0;
      r.action_binding = b;
      r.action_press = p;
      r.action_position = q;
      r.action_hold_ms = h;
      return r;
   endfunction

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      seq_in = seq_ff;
      seq_n_in = seq_n_ff;
      seq_i_in = seq_i_ff;
      stop_in = stop_ff;
      found_in = found_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_ready;
      wr = 1'b0; wi = idx_ff;
      w_act = act_ff[idx_ff]; w_prs = prs_ff[idx_ff]; w_fst = fst_ff[idx_ff];
      w_arm = arm_ff[idx_ff]; w_dl = 1'b0; w_pos = pos_ff[idx_ff];
      w_dlv = c_ff.now_ms + {16'd0, idle_ms};
      r0 = '0; r1 = '0; r2 = '0; r3 = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               st_in = ST_SCAN; idx_in = '0; stop_in = 1'b0;
               found_in = 1'b0; free_ok_in = 1'b0; seq_n_in = '0; seq_i_in = '0;
            end
         end
         ST_SCAN: begin
            seq_n_in = '0; seq_i_in = '0;
            case (c_ff.func)
               FUNC_PRESS: begin
                  if (hit && !found_ff) begin
                     found_in = 1'b1; free_in = idx_ff;
                  end else if (!act_ff[idx_ff] && !free_ok_ff && !found_ff) begin
                     free_ok_in = 1'b1; free_in = idx_ff;
                  end
               end
               FUNC_RELEASE: begin
                  if (hit) begin
                     wr = 1'b1; w_prs = 1'b0; w_arm = 1'b1; w_dl = 1'b1;
                     r0 = mk(BIND_CONT, 1'b0, c_ff.key_position, 16'd0);
                     seq_n_in = 3'd1; stop_in = 1'b1;
                  end
               end
               FUNC_OTHER: begin
                  if (act_ff[idx_ff] && pos_ff[idx_ff] != c_ff.key_position) begin
                     wr = 1'b1;
                     if (!c_ff.key_ign) begin
                        w_act = 1'b0; w_arm = 1'b0; stop_in = 1'b1;
                        r0 = mk(BIND_CONT, 1'b0, pos_ff[idx_ff], 16'd0);
                        r1 = mk(BIND_END, 1'b1, pos_ff[idx_ff], hold_ms);
                        r2 = mk(BIND_END, 1'b0, pos_ff[idx_ff], 16'd0);
                        if (prs_ff[idx_ff]) seq_n_in = 3'd3;
                        else begin r0 = r1; r1 = r2; seq_n_in = 3'd2; end
                     end else if (c_ff.key_down) w_arm = 1'b0;
                     else begin w_arm = 1'b1; w_dl = 1'b1; end
                  end
               end
               FUNC_LAYER: begin
                  if (act_ff[idx_ff] && c_ff.layer_end) begin
                     wr = 1'b1; w_act = 1'b0; w_arm = 1'b0; stop_in = 1'b1;
                     r0 = mk(BIND_CONT, 1'b0, pos_ff[idx_ff], 16'd0);
                     r1 = mk(BIND_END, 1'b1, pos_ff[idx_ff], 16'd0);
                     r2 = mk(BIND_END, 1'b0, pos_ff[idx_ff], 16'd0);
                     if (prs_ff[idx_ff]) seq_n_in = 3'd3;
                     else begin r0 = r1; r1 = r2; seq_n_in = 3'd2; end
                  end
               end
               FUNC_TICK: begin
                  if (arm_ff[idx_ff] && !dsub[31]) begin
                     wr = 1'b1; w_arm = 1'b0;
                     if (act_ff[idx_ff] && !prs_ff[idx_ff]) begin
                        w_act = 1'b0;
                        r0 = mk(BIND_END, 1'b1, pos_ff[idx_ff], hold_ms);
                        r1 = mk(BIND_END, 1'b0, pos_ff[idx_ff], 16'd0);
                        seq_n_in = 3'd2;
                     end
                  end
               end
               default: stop_in = 1'b1;
            endcase
            seq_in[0] = r0; seq_in[1] = r1; seq_in[2] = r2; seq_in[3] = r3;
            if (c_ff.func == FUNC_PRESS) begin
               if (last_slot) st_in = ST_DONE;
               else idx_in = idx_ff + 1'b1;
            end else if (seq_n_in != 3'd0) st_in = ST_EMIT;
            else if (stop_in || last_slot) st_in = ST_IDLE;
            else idx_in = idx_ff + 1'b1;
         end
         ST_DONE: begin
            // press: resolve slot and build the sequence
            wi = free_ff;
            r0 = mk(BIND_START, 1'b1, c_ff.key_position, 16'd0);
            r1 = mk(BIND_START, 1'b0, c_ff.key_position, 16'd0);
            r2 = mk(BIND_CONT, 1'b1, c_ff.key_position, 16'd0);
            stop_in = 1'b1;
            seq_i_in = '0;
            if (!found_ff && !free_ok_ff) begin
               r0 = '0; r0.status = 1'b1; seq_n_in = 3'd1;
            end else begin
               wr = 1'b1; w_act = 1'b1; w_prs = 1'b1; w_fst = 1'b0;
               w_pos = c_ff.key_position;
               w_arm = found_ff ? arm_ff[free_ff] : 1'b0;
               if (found_ff && !fst_ff[free_ff]) begin
                  r0 = r2; seq_n_in = 3'd1;
               end else seq_n_in = 3'd3;
            end
            seq_in[0] = r0; seq_in[1] = r1; seq_in[2] = r2; seq_in[3] = r3;
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               out_in = seq_ff[seq_i_ff[1:0]];
               out_in.last = is_last;
               ov_in = 1'b1;
               seq_i_in = seq_i_ff + 3'd1;
               if (seq_i_ff + 3'd1 == seq_n_ff) begin
                  seq_i_in = '0;
                  if (stop_ff || last_slot) st_in = ST_IDLE;
                  else begin st_in = ST_SCAN; idx_in = idx_ff + 1'b1; end
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0; prs_ff <= '0; fst_ff <= '0; arm_ff <= '0; ov_ff <= 1'b0;
         idx_ff <= '0;
         for (int k = 0; k < SESSION_SLOTS; k++) begin
            pos_ff[k] <= '0; dl_ff[k] <= '0;
         end
      end else begin
         ov_ff <= ov_in;
         idx_ff <= idx_in;
         if (wr) begin
            act_ff[wi] <= w_act; prs_ff[wi] <= w_prs; fst_ff[wi] <= w_fst;
            arm_ff[wi] <= w_arm; pos_ff[wi] <= w_pos;
            if (w_dl) dl_ff[wi] <= w_dlv;
         end
      end
      if (st_ff == ST_IDLE && cmd_valid) c_ff <= cmd_data;
      seq_ff <= seq_in; seq_n_ff <= seq_n_in; seq_i_ff <= seq_i_in;
      stop_ff <= stop_in; found_ff <= found_in; free_ok_ff <= free_ok_in;
      free_ff <= free_in; out_ff <= out_in;
   end

   `TSK_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp moved")
   `TSK_ASSERT(a_idx, clock, reset, idx_ff <= LastIdx, "slot index out of range")
   `TSK_ASSERT(a_seq, clock, reset, st_ff == ST_EMIT |-> seq_i_ff < seq_n_ff, "bad sequence")
endmodule

@@ rtl/tri_state_key_action_tracker.sv @@
// Top level of the tri-state key session tracker: CSRs, front queue, back scanner.
// Depends on tsk_pkg, tsk_front, tsk_back.
//
// channel | handshake          | payload
// req     | req_valid/ready    | req_data (tsk_pkg::req_type)
// rsp     | rsp_valid/ready    | rsp_data (tsk_pkg::rsp_type)
// csr     | csr_we             | csr_index, csr_wdata (64 bit)
//
// The back end picks up an item in its idle state, then scans one slot per cycle
// (up to SESSION_SLOTS slots; a release, non-ignored key or layer item stops at the slot
// it acts on), pausing to emit the results of a slot; a press adds a resolve state. Results
// leave through a result register. A two-entry queue lets the front accept while the back scans.
// Synchronous active-high reset empties all slots and clears the CSRs.
// A stalled rsp holds the scanner; the queue then back-pressures req.
`timescale 1ns / 1ps
module tri_state_key_action_tracker #(
   parameter int SESSION_SLOTS = tsk_pkg::SlotsDefault,
   parameter int KEY_POSITIONS = tsk_pkg::KeysDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsk_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import tsk_pkg::*;

   logic [15:0]  timeout_ff, hold_ff;
   logic [31:0]  lmask_ff;
   logic [127:0] keys_ff;
   logic         cmd_valid, cmd_ready;
   cmd_type      cmd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= '0; hold_ff <= '0; lmask_ff <= '0; keys_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:   timeout_ff <= csr_wdata[15:0];
            CSR_HOLD:      hold_ff <= csr_wdata[15:0];
            CSR_LAYER_IGN: lmask_ff <= csr_wdata[31:0];
            CSR_KEYS_LO:   keys_ff[63:0] <= csr_wdata;
            CSR_KEYS_HI:   keys_ff[127:64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   tsk_front #(.KEY_POSITIONS(KEY_POSITIONS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .layer_mask(lmask_ff), .key_mask(keys_ff),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   tsk_back #(.SESSION_SLOTS(SESSION_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .idle_ms(timeout_ff), .hold_ms(hold_ff),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
